// ===== src/ptp_pkg.sv =====
// ptp_pkg: shared widths, kinds and item types for the point/triangle projection block.
// Used by every module under src; depends on nothing.
package ptp_pkg;

	localparam int COORD_W  = 32;
	localparam int DIFF_W   = 33;
	localparam int PP_W     = 66;
	localparam int DOT_W    = 68;
	localparam int HALF_W   = DOT_W / 2;
	localparam int PROD_W   = 2 * DOT_W;
	localparam int NUM_W    = PROD_W + 2;
	localparam int DIV_W    = PROD_W;
	localparam int WT_W     = 31;
	localparam int NUM_DOTS = 7;
	localparam int QPTR_W   = 2;
	localparam int QDEPTH   = 1 << QPTR_W;
	localparam int QCNT_W   = QPTR_W + 1;

	typedef logic signed [DIFF_W-1:0] diff_t;
	typedef logic signed [PP_W-1:0]   pp_t;
	typedef logic signed [DOT_W-1:0]  dot_t;
	typedef logic signed [PROD_W-1:0] prod_t;
	typedef logic signed [NUM_W-1:0]  num_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic signed [COORD_W-1:0] z;
	} ptp_pt_t;

	typedef enum logic [2:0] {
		KIND_INTERIOR,
		KIND_DEGEN,
		KIND_EDGE_BC,
		KIND_EDGE_AC,
		KIND_EDGE_AB
	} ptp_kind_t;

	// num0/num1 never exceed den; both lanes share den
	typedef struct packed {
		ptp_kind_t        kind;
		logic [DIV_W-1:0] num0;
		logic [DIV_W-1:0] num1;
		logic [DIV_W-1:0] den;
	} ptp_item_t;

endpackage

// ===== src/ptp_mul.sv =====
// ptp_mul: three-stage signed multiplier of two dot-product-width operands, built from
// four half-width partial products into a double-width product. Depends on ptp_pkg.
module ptp_mul (
	input  logic                  clk,
	input  logic                  en,
	input  ptp_pkg::dot_t         a,
	input  ptp_pkg::dot_t         b,
	output ptp_pkg::prod_t        p
);
	import ptp_pkg::*;

	logic [DOT_W-1:0]    ma, mb;
	logic [2*HALF_W-1:0] pll_s1, plh_s1, phl_s1, phh_s1;
	logic                neg_s1, neg_s2;
	logic [PROD_W-1:0]   sum_s2;
	prod_t               p_s3;

	always_comb begin
		ma = a[DOT_W-1] ? unsigned'(-a) : unsigned'(a);
		mb = b[DOT_W-1] ? unsigned'(-b) : unsigned'(b);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pll_s1 <= ma[HALF_W-1:0] * mb[HALF_W-1:0];
			plh_s1 <= ma[HALF_W-1:0] * mb[DOT_W-1:HALF_W];
			phl_s1 <= ma[DOT_W-1:HALF_W] * mb[HALF_W-1:0];
			phh_s1 <= ma[DOT_W-1:HALF_W] * mb[DOT_W-1:HALF_W];
			neg_s1 <= a[DOT_W-1] ^ b[DOT_W-1];
			sum_s2 <= PROD_W'(pll_s1) + (PROD_W'(plh_s1) << HALF_W)
				+ (PROD_W'(phl_s1) << HALF_W) + (PROD_W'(phh_s1) << (2 * HALF_W));
			neg_s2 <= neg_s1;
			p_s3   <= neg_s2 ? -sum_s2 : sum_s2;
		end
	end

	assign p = p_s3;

endmodule

// ===== src/ptp_front.sv =====
// ptp_front: accepts requests, forms dot products and the Gram terms, classifies the
// closest feature and emits a division item. Depends on ptp_pkg and ptp_mul.
module ptp_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  ptp_pkg::ptp_pt_t    pa,
	input  ptp_pkg::ptp_pt_t    pb,
	input  ptp_pkg::ptp_pt_t    pc,
	input  ptp_pkg::ptp_pt_t    pp,
	output logic                in_full,
	input  logic                q_full,
	output logic                item_valid,
	output ptp_pkg::ptp_item_t  item
);
	import ptp_pkg::*;

	localparam int D00 = 0;
	localparam int D01 = 1;
	localparam int D11 = 2;
	localparam int D20 = 3;
	localparam int D21 = 4;
	localparam int DGF = 5;
	localparam int DFF = 6;

	function automatic diff_t dif(input logic signed [COORD_W-1:0] u,
		input logic signed [COORD_W-1:0] v);
		return {u[COORD_W-1], u} - {v[COORD_W-1], v};
	endfunction

	function automatic pp_t mul(input diff_t u, input diff_t v);
		pp_t xu, xv;
		xu = u;
		xv = v;
		return xu * xv;
	endfunction

	function automatic dot_t ext(input pp_t u);
		return {{(DOT_W - PP_W){u[PP_W-1]}}, u};
	endfunction

	function automatic num_t wide(input prod_t u);
		return {{(NUM_W - PROD_W){u[PROD_W-1]}}, u};
	endfunction

	logic en;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8;
	diff_t e0_s1 [3], e1_s1 [3], w_s1 [3], f_s1 [3], g_s1 [3];
	pp_t   pr_s2 [NUM_DOTS][3];
	dot_t  d_s3 [NUM_DOTS], d_s4 [NUM_DOTS], d_s5 [NUM_DOTS], d_s6 [NUM_DOTS];
	prod_t m_p [6];
	num_t  den_s7, nv_s7, nw_s7;
	dot_t  en_s7 [3], ed_s7 [3];
	logic  ez_s7 [3], eo_s7 [3];
	dot_t  en_c [3], ed_c [3];
	num_t  nu;
	ptp_item_t item_c, item_s8;
	logic [1:0] sel;

	assign en         = !v_s8 || !q_full;
	assign in_full    = !en;
	assign item_valid = v_s8;
	assign item       = item_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0; v_s4 <= 1'b0;
			v_s5 <= 1'b0; v_s6 <= 1'b0; v_s7 <= 1'b0; v_s8 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid; v_s2 <= v_s1; v_s3 <= v_s2; v_s4 <= v_s3;
			v_s5 <= v_s4; v_s6 <= v_s5; v_s7 <= v_s6; v_s8 <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			e0_s1[0] <= dif(pb.x, pa.x); e0_s1[1] <= dif(pb.y, pa.y); e0_s1[2] <= dif(pb.z, pa.z);
			e1_s1[0] <= dif(pc.x, pa.x); e1_s1[1] <= dif(pc.y, pa.y); e1_s1[2] <= dif(pc.z, pa.z);
			w_s1[0]  <= dif(pp.x, pa.x); w_s1[1]  <= dif(pp.y, pa.y); w_s1[2]  <= dif(pp.z, pa.z);
			f_s1[0]  <= dif(pc.x, pb.x); f_s1[1]  <= dif(pc.y, pb.y); f_s1[2]  <= dif(pc.z, pb.z);
			g_s1[0]  <= dif(pp.x, pb.x); g_s1[1]  <= dif(pp.y, pb.y); g_s1[2]  <= dif(pp.z, pb.z);
			for (int k = 0; k < 3; k++) begin
				pr_s2[D00][k] <= mul(e0_s1[k], e0_s1[k]);
				pr_s2[D01][k] <= mul(e0_s1[k], e1_s1[k]);
				pr_s2[D11][k] <= mul(e1_s1[k], e1_s1[k]);
				pr_s2[D20][k] <= mul(w_s1[k], e0_s1[k]);
				pr_s2[D21][k] <= mul(w_s1[k], e1_s1[k]);
				pr_s2[DGF][k] <= mul(g_s1[k], f_s1[k]);
				pr_s2[DFF][k] <= mul(f_s1[k], f_s1[k]);
			end
			for (int j = 0; j < NUM_DOTS; j++) begin
				d_s3[j] <= ext(pr_s2[j][0]) + ext(pr_s2[j][1]) + ext(pr_s2[j][2]);
				d_s4[j] <= d_s3[j];
				d_s5[j] <= d_s4[j];
				d_s6[j] <= d_s5[j];
			end
		end
	end

	ptp_mul u_mul_00_11 (.clk(clk), .en(en), .a(d_s3[D00]), .b(d_s3[D11]), .p(m_p[0]));
	ptp_mul u_mul_01_01 (.clk(clk), .en(en), .a(d_s3[D01]), .b(d_s3[D01]), .p(m_p[1]));
	ptp_mul u_mul_11_20 (.clk(clk), .en(en), .a(d_s3[D11]), .b(d_s3[D20]), .p(m_p[2]));
	ptp_mul u_mul_01_21 (.clk(clk), .en(en), .a(d_s3[D01]), .b(d_s3[D21]), .p(m_p[3]));
	ptp_mul u_mul_00_21 (.clk(clk), .en(en), .a(d_s3[D00]), .b(d_s3[D21]), .p(m_p[4]));
	ptp_mul u_mul_01_20 (.clk(clk), .en(en), .a(d_s3[D01]), .b(d_s3[D20]), .p(m_p[5]));

	// edge order: b-c, a-c, a-b
	always_comb begin
		en_c[0] = d_s6[DGF]; ed_c[0] = d_s6[DFF];
		en_c[1] = d_s6[D21]; ed_c[1] = d_s6[D11];
		en_c[2] = d_s6[D20]; ed_c[2] = d_s6[D00];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			den_s7 <= wide(m_p[0]) - wide(m_p[1]);
			nv_s7  <= wide(m_p[2]) - wide(m_p[3]);
			nw_s7  <= wide(m_p[4]) - wide(m_p[5]);
			for (int k = 0; k < 3; k++) begin
				en_s7[k] <= en_c[k];
				ed_s7[k] <= ed_c[k];
				ez_s7[k] <= en_c[k][DOT_W-1] || (en_c[k] == '0) || (ed_c[k] == '0);
				eo_s7[k] <= en_c[k] >= ed_c[k];
			end
			item_s8 <= item_c;
		end
	end

	always_comb begin
		nu          = den_s7 - nv_s7 - nw_s7;
		item_c.kind = KIND_INTERIOR;
		item_c.num0 = nv_s7[DIV_W-1:0];
		item_c.num1 = nw_s7[DIV_W-1:0];
		item_c.den  = den_s7[DIV_W-1:0];
		sel         = 2'd0;
		if (den_s7[NUM_W-1] || den_s7 == '0) begin
			item_c.kind = KIND_DEGEN;
		end else if (nu[NUM_W-1]) begin
			item_c.kind = KIND_EDGE_BC; sel = 2'd0;
		end else if (nv_s7[NUM_W-1]) begin
			item_c.kind = KIND_EDGE_AC; sel = 2'd1;
		end else if (nw_s7[NUM_W-1]) begin
			item_c.kind = KIND_EDGE_AB; sel = 2'd2;
		end
		if (item_c.kind == KIND_DEGEN) begin
			item_c.num0 = '0;
			item_c.num1 = '0;
			item_c.den  = DIV_W'(1);
		end else if (item_c.kind != KIND_INTERIOR) begin
			item_c.num1 = '0;
			if (ez_s7[sel]) begin
				item_c.num0 = '0;
				item_c.den  = DIV_W'(1);
			end else begin
				item_c.den  = DIV_W'(ed_s7[sel][DOT_W-2:0]);
				item_c.num0 = eo_s7[sel] ? DIV_W'(ed_s7[sel][DOT_W-2:0])
					: DIV_W'(en_s7[sel][DOT_W-2:0]);
			end
		end
	end

endmodule

// ===== src/ptp_queue.sv =====
// ptp_queue: small FIFO of classified items between front and back.
// Depends on ptp_pkg.
module ptp_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  ptp_pkg::ptp_item_t  wr_item,
	output logic                full,
	input  logic                pop,
	output logic                empty,
	output ptp_pkg::ptp_item_t  rd_item
);
	import ptp_pkg::*;

	ptp_item_t          mem_q [QDEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0]  cnt_q;
	logic               do_push, do_pop;

	assign full    = cnt_q == QCNT_W'(QDEPTH);
	assign empty   = cnt_q == '0;
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rd_item = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			if (do_push && !do_pop) cnt_q <= cnt_q + 1'b1;
			else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_ptr_q] <= wr_item;
	end

endmodule

// ===== src/ptp_back.sv =====
// ptp_back: two-lane pipelined restoring divider (one quotient bit per stage) and
// the weight output register. Depends on ptp_pkg.
module ptp_back #(
	parameter int W = 30
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	input  ptp_pkg::ptp_item_t     item,
	output logic                   in_pop,
	output logic                   empty,
	input  logic                   pop,
	output logic [ptp_pkg::WT_W-1:0] weight_a,
	output logic [ptp_pkg::WT_W-1:0] weight_b,
	output logic [ptp_pkg::WT_W-1:0] weight_c,
	output logic                   degenerate
);
	import ptp_pkg::*;

	localparam int QW = W + 1;
	localparam logic [WT_W-1:0] S = WT_W'(1) << W;

	function automatic logic [DIV_W:0] div_step(input logic [DIV_W:0] x,
		input logic [DIV_W-1:0] d);
		logic [DIV_W:0] dx;
		dx = {1'b0, d};
		if (x >= dx) return {1'b1, DIV_W'(x - dx)};
		return {1'b0, x[DIV_W-1:0]};
	endfunction

	logic              en;
	logic              vld_s  [QW];
	logic [DIV_W-1:0]  rem0_s [QW], rem1_s [QW], den_s [QW];
	logic [QW-1:0]     qa_s   [QW], qb_s [QW];
	ptp_kind_t         kind_s [QW];
	logic              out_vld_q, deg_q;
	logic [WT_W-1:0]   wa_q, wb_q, wc_q;
	logic [WT_W-1:0]   wa, wb, wc, q0, q1, rest;

	assign en     = !out_vld_q || pop;
	assign in_pop = en && in_valid;
	assign empty  = !out_vld_q;

	for (genvar k = 0; k < QW; k++) begin : g_stage
		logic [DIV_W:0]   x0, x1, r0, r1;
		logic [DIV_W-1:0] dd;
		logic [QW-1:0]    qa_in, qb_in;
		ptp_kind_t        kd;
		logic             vin;
		if (k == 0) begin : g_first
			always_comb begin
				x0    = {1'b0, item.num0};
				x1    = {1'b0, item.num1};
				dd    = item.den;
				qa_in = '0;
				qb_in = '0;
				kd    = item.kind;
				vin   = in_pop;
			end
		end else begin : g_next
			always_comb begin
				x0    = {rem0_s[k-1], 1'b0};
				x1    = {rem1_s[k-1], 1'b0};
				dd    = den_s[k-1];
				qa_in = qa_s[k-1];
				qb_in = qb_s[k-1];
				kd    = kind_s[k-1];
				vin   = vld_s[k-1];
			end
		end
		always_comb begin
			r0 = div_step(x0, dd);
			r1 = div_step(x1, dd);
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) vld_s[k] <= 1'b0;
			else if (en) vld_s[k] <= vin;
		end
		always_ff @(posedge clk) begin
			if (en) begin
				rem0_s[k] <= r0[DIV_W-1:0];
				rem1_s[k] <= r1[DIV_W-1:0];
				qa_s[k]   <= {qa_in[QW-2:0], r0[DIV_W]};
				qb_s[k]   <= {qb_in[QW-2:0], r1[DIV_W]};
				den_s[k]  <= dd;
				kind_s[k] <= kd;
			end
		end
	end

	always_comb begin
		q0   = WT_W'(qa_s[QW-1]);
		q1   = WT_W'(qb_s[QW-1]);
		wa   = '0;
		wb   = '0;
		wc   = '0;
		rest = '0;
		case (kind_s[QW-1])
			KIND_DEGEN: begin
				wa = S;
			end
			KIND_EDGE_BC: begin
				wb = S - q0; wc = q0;
			end
			KIND_EDGE_AC: begin
				wa = S - q0; wc = q0;
			end
			KIND_EDGE_AB: begin
				wa = S - q0; wb = q0;
			end
			KIND_INTERIOR: begin
				wb   = (q0 > S) ? S : q0;
				rest = S - wb;
				wc   = (q1 > rest) ? rest : q1;
				wa   = rest - wc;
			end
			default: begin
				wa = S;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_vld_q <= 1'b0;
		else if (en) out_vld_q <= vld_s[QW-1];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			wa_q  <= wa;
			wb_q  <= wb;
			wc_q  <= wc;
			deg_q <= kind_s[QW-1] == KIND_DEGEN;
		end
	end

	assign weight_a   = wa_q;
	assign weight_b   = wb_q;
	assign weight_c   = wc_q;
	assign degenerate = deg_q;

	a_sum_one: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q |-> (33'(wa_q) + 33'(wb_q) + 33'(wc_q)) == 33'(S))
		else $error("weights do not sum to one");

	a_degen: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q && deg_q |-> wa_q == S && wb_q == '0 && wc_q == '0)
		else $error("degenerate result with wrong weights");

	a_no_loss: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[QW-1] && en |=> out_vld_q)
		else $error("divider result dropped");

endmodule

// ===== src/point_triangle_projection.sv =====
// point_triangle_projection: top level; barycentric weights of the closest point
// of a triangle to a query point. Depends on ptp_pkg, ptp_front, ptp_queue, ptp_back.
//
// Usage:
//  Input side is a queue write port: drive the twelve Q16.16 coordinates with push;
//  a request is taken on a clock edge with push high and full low.
//  Result side is a queue read port: while empty is low, weight_a/b/c (Q1.30) and
//  degenerate show the oldest result; it is taken on an edge with pop high.
//  Throughput: one request per cycle sustained while pop keeps up and full stays low.
//  Path from the accepting edge to a visible result: the 8-stage front (dot products,
//  3-stage wide multipliers, classify), one queue slot, the divider, which resolves one
//  quotient bit per stage (WEIGHT_FRAC_BITS + 1 stages), and the output register.
//  Reset: asynchronous, active low; empties every pipeline and the queue, full
//  and empty come up low and high.
//  Receiver stall: the output register holds; the divider pipeline freezes, the
//  front keeps filling the 4-entry queue, then full rises until pop resumes.
module point_triangle_projection #(
	parameter int WEIGHT_FRAC_BITS = 30
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic signed [31:0] ax,
	input  logic signed [31:0] ay,
	input  logic signed [31:0] az,
	input  logic signed [31:0] bx,
	input  logic signed [31:0] by,
	input  logic signed [31:0] bz,
	input  logic signed [31:0] cx,
	input  logic signed [31:0] cy,
	input  logic signed [31:0] cz,
	input  logic signed [31:0] px,
	input  logic signed [31:0] py,
	input  logic signed [31:0] pz,
	output logic        empty,
	input  logic        pop,
	output logic [30:0] weight_a,
	output logic [30:0] weight_b,
	output logic [30:0] weight_c,
	output logic        degenerate
);
	import ptp_pkg::*;

	ptp_pt_t   pa, pb, pc, pp;
	logic      f_valid, q_full, q_empty, q_pop;
	ptp_item_t f_item, q_item;

	assign pa = '{x: ax, y: ay, z: az};
	assign pb = '{x: bx, y: by, z: bz};
	assign pc = '{x: cx, y: cy, z: cz};
	assign pp = '{x: px, y: py, z: pz};

	ptp_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(push),
		.pa(pa), .pb(pb), .pc(pc), .pp(pp),
		.in_full(full), .q_full(q_full),
		.item_valid(f_valid), .item(f_item)
	);

	ptp_queue u_queue (
		.clk(clk), .arst_n(arst_n),
		.push(f_valid), .wr_item(f_item), .full(q_full),
		.pop(q_pop), .empty(q_empty), .rd_item(q_item)
	);

	ptp_back #(.W(WEIGHT_FRAC_BITS)) u_back (
		.clk(clk), .arst_n(arst_n),
		.in_valid(!q_empty), .item(q_item), .in_pop(q_pop),
		.empty(empty), .pop(pop),
		.weight_a(weight_a), .weight_b(weight_b), .weight_c(weight_c),
		.degenerate(degenerate)
	);

endmodule

// ===== bench/tb.sv =====
// tb: self-checking bench for point_triangle_projection (barycentric weights of a point
// against a triangle). Wide-integer predictor, scoreboard class, queue-style drivers.
// Depends on ptp_pkg and the RTL under src.
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import ptp_pkg::*;

	localparam int WFB = 30;
	localparam int WD_LIMIT = 5000;
	localparam logic [30:0] ONE_W = 31'(1) << WFB;

	typedef logic signed [255:0] wide_t;

	typedef struct packed {
		ptp_pt_t a;
		ptp_pt_t b;
		ptp_pt_t c;
		ptp_pt_t p;
	} tri_req_t;

	typedef struct packed {
		logic [30:0] wa;
		logic [30:0] wb;
		logic [30:0] wc;
		logic        deg;
	} weights_t;

	function automatic wide_t dot3(wide_t x0, wide_t y0, wide_t z0, wide_t x1, wide_t y1,
		wide_t z1);
		return x0 * x1 + y0 * y1 + z0 * z1;
	endfunction

	function automatic wide_t wx(logic signed [31:0] v);
		return wide_t'(v);
	endfunction

	// clamped edge parameter scaled by 2^WFB
	function automatic logic [30:0] edge_t(wide_t n, wide_t d);
		wide_t q;
		if (n <= 0 || d <= 0)
			return '0;
		if (n >= d)
			return ONE_W;
		q = (n * (wide_t'(1) <<< WFB)) / d;
		return q[30:0];
	endfunction

	function automatic weights_t project_weights(tri_req_t r);
		wide_t e0x, e0y, e0z, e1x, e1y, e1z, vx, vy, vz, fx, fy, fz;
		wide_t d00, d01, d11, d20, d21, den, nv, nw, nu, qb, qc, sc;
		weights_t o;
		logic [30:0] t;
		sc = wide_t'(1) <<< WFB;
		e0x = wx(r.b.x) - wx(r.a.x); e0y = wx(r.b.y) - wx(r.a.y); e0z = wx(r.b.z) - wx(r.a.z);
		e1x = wx(r.c.x) - wx(r.a.x); e1y = wx(r.c.y) - wx(r.a.y); e1z = wx(r.c.z) - wx(r.a.z);
		vx = wx(r.p.x) - wx(r.a.x); vy = wx(r.p.y) - wx(r.a.y); vz = wx(r.p.z) - wx(r.a.z);
		d00 = dot3(e0x, e0y, e0z, e0x, e0y, e0z);
		d01 = dot3(e0x, e0y, e0z, e1x, e1y, e1z);
		d11 = dot3(e1x, e1y, e1z, e1x, e1y, e1z);
		d20 = dot3(vx, vy, vz, e0x, e0y, e0z);
		d21 = dot3(vx, vy, vz, e1x, e1y, e1z);
		den = d00 * d11 - d01 * d01;
		o = '0;
		if (den <= 0) begin
			o.wa = ONE_W;
			o.deg = 1'b1;
			return o;
		end
		nv = d11 * d20 - d01 * d21;
		nw = d00 * d21 - d01 * d20;
		nu = den - nv - nw;
		if (nu < 0) begin
			fx = wx(r.c.x) - wx(r.b.x); fy = wx(r.c.y) - wx(r.b.y); fz = wx(r.c.z) - wx(r.b.z);
			t = edge_t(dot3(wx(r.p.x) - wx(r.b.x), wx(r.p.y) - wx(r.b.y),
				wx(r.p.z) - wx(r.b.z), fx, fy, fz), dot3(fx, fy, fz, fx, fy, fz));
			o.wb = ONE_W - t;
			o.wc = t;
		end else if (nv < 0) begin
			t = edge_t(d21, d11);
			o.wa = ONE_W - t;
			o.wc = t;
		end else if (nw < 0) begin
			t = edge_t(d20, d00);
			o.wa = ONE_W - t;
			o.wb = t;
		end else begin
			qb = (nv * sc) / den;
			qc = (nw * sc) / den;
			if (qb > sc)
				qb = sc;
			if (qc > sc - qb)
				qc = sc - qb;
			o.wb = qb[30:0];
			o.wc = qc[30:0];
			o.wa = ONE_W - o.wb - o.wc;
		end
		return o;
	endfunction

	class weight_board;
		weights_t pending_q[$];
		int errors = 0;

		function void note_request(tri_req_t r);
			pending_q.push_back(project_weights(r));
		endfunction

		function void check_result(weights_t got);
			weights_t exp_w;
			if (pending_q.size() == 0) begin
				$display("%0t: unexpected result wa=%0d wb=%0d wc=%0d deg=%0d",
					$time, got.wa, got.wb, got.wc, got.deg);
				errors++;
				return;
			end
			exp_w = pending_q.pop_front();
			if (got.wa !== exp_w.wa) begin
				$display("%0t: weight_a exp %0d got %0d", $time, exp_w.wa, got.wa);
				errors++;
			end
			if (got.wb !== exp_w.wb) begin
				$display("%0t: weight_b exp %0d got %0d", $time, exp_w.wb, got.wb);
				errors++;
			end
			if (got.wc !== exp_w.wc) begin
				$display("%0t: weight_c exp %0d got %0d", $time, exp_w.wc, got.wc);
				errors++;
			end
			if (got.deg !== exp_w.deg) begin
				$display("%0t: degenerate exp %0d got %0d", $time, exp_w.deg, got.deg);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic pop = 1'b0;
	logic full, empty, degenerate;
	logic [30:0] weight_a, weight_b, weight_c;
	tri_req_t req = '0;
	int idle_pct = 0;
	int stall_pct = 0;
	int quiet_cycles = 0;
	weight_board board = new();

	always #5 clk = ~clk;

	point_triangle_projection #(.WEIGHT_FRAC_BITS(WFB)) u_top (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full),
		.ax(req.a.x), .ay(req.a.y), .az(req.a.z),
		.bx(req.b.x), .by(req.b.y), .bz(req.b.z),
		.cx(req.c.x), .cy(req.c.y), .cz(req.c.z),
		.px(req.p.x), .py(req.p.y), .pz(req.p.z),
		.empty(empty), .pop(pop),
		.weight_a(weight_a), .weight_b(weight_b), .weight_c(weight_c),
		.degenerate(degenerate)
	);

	always @(posedge clk) begin
		if (arst_n) begin
			pop <= ($urandom_range(99) >= stall_pct);
			if (push && !full)
				board.note_request(req);
			if (pop && !empty)
				board.check_result({weight_a, weight_b, weight_c, degenerate});
			if ((push && !full) || (pop && !empty))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WD_LIMIT) begin
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	task automatic send_request(tri_req_t r);
		while ($urandom_range(99) < idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		req <= r;
		@(posedge clk);
		while (full)
			@(posedge clk);
	endtask

	task automatic drain();
		push <= 1'b0;
		@(posedge clk);
		while (board.pending_q.size() != 0)
			@(posedge clk);
	endtask

	function automatic ptp_pt_t pt(int x, int y, int z);
		ptp_pt_t v;
		v.x = x; v.y = y; v.z = z;
		return v;
	endfunction

	function automatic ptp_pt_t rnd_pt(int span);
		ptp_pt_t v;
		if (span == 0) begin
			v.x = $urandom; v.y = $urandom; v.z = $urandom;
		end else begin
			v.x = $urandom_range(2 * span) - span;
			v.y = $urandom_range(2 * span) - span;
			v.z = $urandom_range(2 * span) - span;
		end
		return v;
	endfunction

	function automatic tri_req_t rnd_request();
		tri_req_t r;
		int span, k;
		case ($urandom_range(9))
			0, 1: span = 0;
			2, 3: span = 1 << 24;
			4, 5: span = 1 << 16;
			default: span = 1 << ($urandom_range(12) + 2);
		endcase
		r.a = rnd_pt(span); r.b = rnd_pt(span); r.c = rnd_pt(span); r.p = rnd_pt(span);
		case ($urandom_range(19))
			0: begin
				k = $urandom_range(6) - 3;
				r.a = rnd_pt(1 << 12); r.b = rnd_pt(1 << 12);
				r.c.x = r.a.x + k * (r.b.x - r.a.x);
				r.c.y = r.a.y + k * (r.b.y - r.a.y);
				r.c.z = r.a.z + k * (r.b.z - r.a.z);
			end
			1: r.b = r.a;
			2: r.p = r.b;
			3: r.p = r.c;
			default: ;
		endcase
		return r;
	endfunction

	initial begin
		localparam int U = 1 << 16;
		localparam int MX = 32'h7fffffff;
		localparam int MN = 32'h80000000;
		tri_req_t r;
		ptp_pt_t o, ex, ey;
		int phase_items;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		o = pt(0, 0, 0); ex = pt(U, 0, 0); ey = pt(0, U, 0);
		r = {o, ex, ey, pt(U / 4, U / 4, 5 * U)};    send_request(r);
		r = {o, ex, ey, pt(U, U, 0)};                send_request(r);
		r = {o, ex, ey, pt(-U, U / 2, 0)};           send_request(r);
		r = {o, ex, ey, pt(U / 2, -U, 0)};           send_request(r);
		r = {o, ex, ey, pt(3 * U, -U, 0)};           send_request(r);
		r = {o, ex, ey, pt(-U, -U, 0)};              send_request(r);
		r = {o, ex, ey, pt(-U, 3 * U, 7)};           send_request(r);
		r = {o, ex, ey, pt(U / 2, 0, 0)};            send_request(r);
		r = {o, ex, ey, pt(U / 2, U / 2, 0)};        send_request(r);
		r = {o, ex, ey, o};                          send_request(r);
		r = {o, o, o, o};                            send_request(r);
		r = {o, ex, pt(2 * U, 0, 0), ey};            send_request(r);
		r = {pt(MN, MN, MN), pt(MX, MX, MX), pt(MN, MX, 0), pt(0, 0, 0)}; send_request(r);
		r = {pt(MX, MN, MX), pt(MN, MX, MN), pt(MX, MX, MN), pt(MN, MN, MX)}; send_request(r);
		r = {pt(MX, MX, MX), pt(MX, MX, MX), pt(MX, MX, MX), pt(MN, MN, MN)}; send_request(r);
		r = {pt(-1, -1, -1), pt(MN, 0, 0), pt(0, MN, 0), pt(MX, MX, MX)};  send_request(r);
		drain();
		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 51; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 51; end
				3: begin idle_pct = 33; stall_pct = 33; end
				default: begin idle_pct = 0; stall_pct = 0; end
			endcase
			phase_items = (ph == 4) ? 350 : 400;
			for (int i = 0; i < phase_items; i++)
				send_request(rnd_request());
			drain();
		end
		repeat (60) @(posedge clk);
		if (board.errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end
endmodule
